>>> hdl/sbc_pkg.sv
// sbc_pkg: shared widths, the pipeline side-band struct and the square root step
// for the sphere versus box contact pipeline
// no dependencies
`default_nettype none

package sbc_pkg;

  localparam int FracBitsDef = 16;
  localparam int CoordW      = 32;
  localparam int RadW        = 31;
  localparam int NormW       = 18;
  localparam int DepthW      = 31;
  localparam int InTdataW    = 320;
  localparam int OutTdataW   = 184;
  localparam int SqW         = 64;
  localparam int SqSteps     = 32;

  // data that rides along with an item through the pipeline
  typedef struct packed {
    logic [2:0][CoordW-1:0] c;
    logic [RadW-1:0]        r;
    logic                   hit;
    logic                   outside;
    logic [2:0]             neg;
    logic [2:0][RadW-1:0]   mag;
    logic [1:0]             axis;
    logic                   face_pos;
    logic [DepthW-1:0]      depth;
  } side_t;

  // remainder and partial root of the bitwise square root
  typedef struct packed {
    logic [SqW-1:0] v;
    logic [SqW-1:0] res;
  } root_t;

  // one step of the digit-by-digit square root
  function automatic root_t root_step(root_t x, logic [SqW-1:0] bit_val);
    root_t          y;
    logic [SqW-1:0] t;
    t = x.res + bit_val;
    if (x.v >= t) begin
      y.v   = x.v - t;
      y.res = (x.res >> 1) + bit_val;
    end else begin
      y.v   = x.v;
      y.res = x.res >> 1;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sbc_front.sv
// sbc_front: clamp, gap, face distances, squares and the overlap test (four stages)
// depends on sbc_pkg
`default_nettype none

module sbc_front
  import sbc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [2:0][CoordW-1:0] c_i,
  input  wire logic [RadW-1:0]        r_i,
  input  wire logic [2:0][CoordW-1:0] lo_i,
  input  wire logic [2:0][CoordW-1:0] hi_i,
  output logic                        valid_o,
  output side_t                       side_o,
  output logic [SqW-1:0]              sq_o
);

  logic [3:0] vld_q;

  // stage 1 signals
  logic signed [CoordW:0] gap_d [3];
  logic signed [CoordW:0] fd_d [6];
  logic signed [CoordW:0] gap_q [3];
  logic signed [CoordW:0] fd_q [6];
  side_t                  sd1_q, sd1_d;
  logic signed [CoordW-1:0] cs, ls, hs, qs;

  // stage 2 signals
  logic [CoordW:0]        mag_d [3];
  logic [CoordW:0]        mag_q [3];
  logic [2:0]             far_d, far_q;
  logic signed [CoordW:0] pmin_d [3];
  logic signed [CoordW:0] pmin_q [3];
  logic [2:0]             ppos_d, ppos_q;
  logic                   any_d;
  side_t                  sd2_q, sd2_d;

  // stage 3 signals
  logic [2*RadW-1:0]      sqa_q [3];
  logic [2*RadW-1:0]      rr_q;
  logic                   far3_q;
  logic signed [CoordW:0] best_d, best_q;
  logic [1:0]             axis_d;
  logic                   pos_d;
  side_t                  sd3_q, sd3_d;

  // stage 4 signals
  logic [SqW-1:0]         sq_sum;
  logic [CoordW+1:0]      dsum;
  side_t                  sd4_d, sd4_q;
  logic [SqW-1:0]         sq4_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage 1: clamp the center and take the gap and face distances
  always_comb begin
    cs = '0;
    ls = '0;
    hs = '0;
    qs = '0;
    for (int k = 0; k < 3; k++) begin
      cs = $signed(c_i[k]);
      ls = $signed(lo_i[k]);
      hs = $signed(hi_i[k]);
      if (cs < ls) begin
        qs = ls;
      end else if (cs > hs) begin
        qs = hs;
      end else begin
        qs = cs;
      end
      gap_d[k]    = {cs[CoordW-1], cs} - {qs[CoordW-1], qs};
      fd_d[2*k]   = {cs[CoordW-1], cs} - {ls[CoordW-1], ls};
      fd_d[2*k+1] = {hs[CoordW-1], hs} - {cs[CoordW-1], cs};
    end
    sd1_d   = '0;
    sd1_d.c = c_i;
    sd1_d.r = r_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gap_q <= gap_d;
      fd_q  <= fd_d;
      sd1_q <= sd1_d;
    end
  end

  // stage 2: gap magnitudes, reach test per axis, nearer face per axis
  always_comb begin
    any_d = 1'b0;
    sd2_d = sd1_q;
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = gap_q[k][CoordW] ? (~gap_q[k] + 1'b1) : gap_q[k];
      far_d[k] = mag_d[k] > {2'b00, sd1_q.r};
      sd2_d.neg[k] = gap_q[k][CoordW];
      if (gap_q[k] != '0) begin
        any_d = 1'b1;
      end
      if (fd_q[2*k+1] < fd_q[2*k]) begin
        pmin_d[k] = fd_q[2*k+1];
        ppos_d[k] = 1'b1;
      end else begin
        pmin_d[k] = fd_q[2*k];
        ppos_d[k] = 1'b0;
      end
    end
    sd2_d.outside = any_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      far_q  <= far_d;
      pmin_q <= pmin_d;
      ppos_q <= ppos_d;
      sd2_q  <= sd2_d;
    end
  end

  // stage 3: squares and the nearest face, earlier faces win ties
  always_comb begin
    best_d = pmin_q[0];
    axis_d = 2'd0;
    pos_d  = ppos_q[0];
    if (pmin_q[1] < best_d) begin
      best_d = pmin_q[1];
      axis_d = 2'd1;
      pos_d  = ppos_q[1];
    end
    if (pmin_q[2] < best_d) begin
      best_d = pmin_q[2];
      axis_d = 2'd2;
      pos_d  = ppos_q[2];
    end
    sd3_d = sd2_q;
    sd3_d.axis     = axis_d;
    sd3_d.face_pos = pos_d;
    for (int k = 0; k < 3; k++) begin
      sd3_d.mag[k] = mag_q[k][RadW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sqa_q[k] <= mag_q[k][RadW-1:0] * mag_q[k][RadW-1:0];
      end
      rr_q   <= sd2_q.r * sd2_q.r;
      far3_q <= |far_q;
      best_q <= best_d;
      sd3_q  <= sd3_d;
    end
  end

  // stage 4: squared gap, overlap test and the inside depth
  always_comb begin
    sq_sum = SqW'(sqa_q[0]) + SqW'(sqa_q[1]) + SqW'(sqa_q[2]);
    sd4_d  = sd3_q;
    if (sd3_q.outside) begin
      sd4_d.hit = !far3_q && (sq_sum <= SqW'(rr_q));
    end else begin
      sd4_d.hit = 1'b1;
    end
    if (best_q > $signed({(CoordW+1){1'b0}})) begin
      dsum = {3'b000, sd3_q.r} + {1'b0, best_q};
    end else begin
      dsum = {3'b000, sd3_q.r};
    end
    sd4_d.depth = (|dsum[CoordW+1:DepthW]) ? {DepthW{1'b1}} : dsum[DepthW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd4_q <= sd4_d;
      sq4_q <= sq_sum;
    end
  end

  assign valid_o = vld_q[3];
  assign side_o  = sd4_q;
  assign sq_o    = sq4_q;

endmodule

`default_nettype wire

>>> hdl/sbc_sqrt.sv
// sbc_sqrt: pipelined integer square root of the squared gap, one result bit a stage
// depends on sbc_pkg
`default_nettype none

module sbc_sqrt
  import sbc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire side_t          side_i,
  input  wire logic [SqW-1:0] sq_i,
  output logic                valid_o,
  output side_t               side_o,
  output logic [RadW-1:0]     len_o
);

  logic [SqSteps-1:0] vld_q;
  root_t              root_in [SqSteps];
  root_t              root_q  [SqSteps];
  side_t              side_in [SqSteps];
  side_t              side_q  [SqSteps];
  logic               vld_in  [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_step
    localparam logic [SqW-1:0] BitVal = SqW'(1) << (2 * (SqSteps - 1 - k));

    if (k == 0) begin : g_first
      assign root_in[k] = {sq_i, {SqW{1'b0}}};
      assign side_in[k] = side_i;
      assign vld_in[k]  = valid_i;
    end else begin : g_next
      assign root_in[k] = root_q[k-1];
      assign side_in[k] = side_q[k-1];
      assign vld_in[k]  = vld_q[k-1];
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    // one root bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_step(root_in[k], BitVal);
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[SqSteps-1];
  assign side_o  = side_q[SqSteps-1];
  assign len_o   = root_q[SqSteps-1].res[RadW-1:0];

endmodule

`default_nettype wire

>>> hdl/sbc_div.sv
// sbc_div: three-lane restoring divider for the normal, one quotient bit a stage
// depends on sbc_pkg
`default_nettype none

module sbc_div
  import sbc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire side_t                   side_i,
  input  wire logic [RadW-1:0]         len_i,
  output logic                         valid_o,
  output side_t                        side_o,
  output logic [2:0][FRAC_BITS:0]      quo_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = RadW + FRAC_BITS + 1;
  localparam int NS = QW + 1;

  logic [NS-1:0]          vld_q;
  side_t                  side_q [NS];
  logic [RadW-1:0]        len_q  [NS];
  logic [2:0][RadW-1:0]   rem_q  [NS];
  logic [2:0][QW-1:0]     low_q  [NS];

  logic [DW-1:0]          dvd [3];
  side_t                  side0_d;

  // entry: dividend with rounding term, and the outside depth
  always_comb begin
    side0_d = side_i;
    if (side_i.outside) begin
      side0_d.depth = side_i.r - len_i;
    end
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (DW'(side_i.mag[k]) << FRAC_BITS) + DW'(len_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side0_d;
      len_q[0]  <= len_i;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= dvd[k][DW-1:QW];
        low_q[0][k] <= dvd[k][QW-1:0];
      end
    end
  end

  // quotient bit stages
  for (genvar s = 1; s < NS; s++) begin : g_step
    logic [RadW:0]        trial [3];
    logic [2:0][RadW-1:0] rem_d;
    logic [2:0][QW-1:0]   low_d;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem_q[s-1][k], low_q[s-1][k][QW-1]};
        if (trial[k] >= {1'b0, len_q[s-1]}) begin
          rem_d[k] = RadW'(trial[k] - {1'b0, len_q[s-1]});
          low_d[k] = {low_q[s-1][k][QW-2:0], 1'b1};
        end else begin
          rem_d[k] = trial[k][RadW-1:0];
          low_d[k] = {low_q[s-1][k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
        len_q[s]  <= len_q[s-1];
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign quo_o   = low_q[NS-1];

endmodule

`default_nettype wire

>>> hdl/sbc_back.sv
// sbc_back: normal selection, normal times radius, rounding and point saturation
// depends on sbc_pkg
`default_nettype none

module sbc_back
  import sbc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire side_t                   side_i,
  input  wire logic [2:0][FRAC_BITS:0] quo_i,
  output logic                         valid_o,
  output logic                         overlap_o,
  output logic [2:0][NormW-1:0]        normal_o,
  output logic [DepthW-1:0]            depth_o,
  output logic [2:0][CoordW-1:0]       point_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int PW = QW + RadW;
  localparam int XW = (QW + 1 > NormW) ? QW + 1 : NormW;
  localparam logic [QW-1:0] One  = QW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);

  logic [1:0]          vld_q;
  logic [QW-1:0]       m_d [3];
  logic [2:0]          sg_d;
  logic [QW-1:0]       m_q [3];
  logic [2:0]          sg_q;
  logic [PW-1:0]       prod_q [3];
  side_t               sd_q;

  logic [PW-1:0]       rsum [3];
  logic [CoordW-1:0]   rnd [3];
  logic signed [CoordW+1:0] pw [3];
  logic signed [XW-1:0] nx [3];

  logic                      ovl_q;
  logic [2:0][NormW-1:0]     nrm_q, nrm_d;
  logic [DepthW-1:0]         dep_q;
  logic [2:0][CoordW-1:0]    pt_q, pt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // normal magnitude and sign: divided gap outside, face axis inside
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (side_i.outside) begin
        m_d[k]  = quo_i[k];
        sg_d[k] = side_i.neg[k];
      end else if (side_i.axis == 2'(k)) begin
        m_d[k]  = One;
        sg_d[k] = !side_i.face_pos;
      end else begin
        m_d[k]  = '0;
        sg_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= PW'(m_d[k]) * PW'(side_i.r);
      end
      m_q  <= m_d;
      sg_q <= sg_d;
      sd_q <= side_i;
    end
  end

  // round the offset, move the center and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = prod_q[k] + Half;
      rnd[k]  = CoordW'(rsum[k] >> FRAC_BITS);
      if (sg_q[k]) begin
        pw[k] = $signed({sd_q.c[k][CoordW-1], sd_q.c[k][CoordW-1], sd_q.c[k]})
              + $signed({2'b00, rnd[k]});
        nx[k] = -$signed(XW'(m_q[k]));
      end else begin
        pw[k] = $signed({sd_q.c[k][CoordW-1], sd_q.c[k][CoordW-1], sd_q.c[k]})
              - $signed({2'b00, rnd[k]});
        nx[k] = $signed(XW'(m_q[k]));
      end
      if (pw[k] > $signed({3'b000, {(CoordW-1){1'b1}}})) begin
        pt_d[k] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (pw[k] < $signed({3'b111, {(CoordW-1){1'b0}}})) begin
        pt_d[k] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        pt_d[k] = pw[k][CoordW-1:0];
      end
      nrm_d[k] = nx[k][NormW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovl_q <= sd_q.hit;
      nrm_q <= sd_q.hit ? nrm_d : '0;
      dep_q <= sd_q.hit ? sd_q.depth : '0;
      pt_q  <= sd_q.hit ? pt_d : '0;
    end
  end

  assign valid_o   = vld_q[1];
  assign overlap_o = ovl_q;
  assign normal_o  = nrm_q;
  assign depth_o   = dep_q;
  assign point_o   = pt_q;

endmodule

`default_nettype wire

>>> hdl/sphere_box_contact_core.sv
// sphere_box_contact_core: top level of the sphere versus box contact pipeline
// depends on sbc_pkg, sbc_front, sbc_sqrt, sbc_div, sbc_back
//
// Usage: one beat on the s_axis channel carries a sphere (center, radius) and an
// axis-aligned box in signed fixed point; one beat on the m_axis channel returns
// overlap, a unit normal, the penetration depth and the contact point.
// Every input beat gives exactly one output beat, in order.
// The pipeline has four front stages, 32 square root stages,
// FRAC_BITS + 2 divider stages and two output stages. Throughput is one beat
// per cycle unless the output stalls; each stage holds one item.
// Reset clears all stage valid bits, so the pipeline comes up empty and ready.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes, s_axis_tready drops, and nothing is lost or repeated;
// beats keep flowing into empty slots while the output is free.
`default_nettype none

module sphere_box_contact_core
  import sbc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // center_x, center_y, center_z, sphere_radius, box_min_x, box_min_y,
  // box_min_z, box_max_x, box_max_y, box_max_z, zero pad
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // overlap, point_valid, normal_x, normal_y, normal_z, depth,
  // point_x, point_y, point_z, zero pad
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  logic                   en;
  logic [2:0][CoordW-1:0] c, lo, hi;
  logic [RadW-1:0]        r;

  logic                   f_vld, s_vld, d_vld;
  side_t                  f_side, s_side, d_side;
  logic [SqW-1:0]         f_sq;
  logic [RadW-1:0]        s_len;
  logic [2:0][FRAC_BITS:0] d_quo;

  logic                   ovl;
  logic [2:0][NormW-1:0]  nrm;
  logic [DepthW-1:0]      dep;
  logic [2:0][CoordW-1:0] pt;

  // the pipeline moves unless a finished result is held back
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the input beat
  assign c[0]  = s_axis_tdata[31:0];
  assign c[1]  = s_axis_tdata[63:32];
  assign c[2]  = s_axis_tdata[95:64];
  assign r     = s_axis_tdata[126:96];
  assign lo[0] = s_axis_tdata[158:127];
  assign lo[1] = s_axis_tdata[190:159];
  assign lo[2] = s_axis_tdata[222:191];
  assign hi[0] = s_axis_tdata[254:223];
  assign hi[1] = s_axis_tdata[286:255];
  assign hi[2] = s_axis_tdata[318:287];

  sbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .c_i     (c),
    .r_i     (r),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (f_vld),
    .side_o  (f_side),
    .sq_o    (f_sq)
  );

  sbc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .side_i  (f_side),
    .sq_i    (f_sq),
    .valid_o (s_vld),
    .side_o  (s_side),
    .len_o   (s_len)
  );

  sbc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .side_i  (s_side),
    .len_i   (s_len),
    .valid_o (d_vld),
    .side_o  (d_side),
    .quo_o   (d_quo)
  );

  sbc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (d_vld),
    .side_i    (d_side),
    .quo_i     (d_quo),
    .valid_o   (m_axis_tvalid),
    .overlap_o (ovl),
    .normal_o  (nrm),
    .depth_o   (dep),
    .point_o   (pt)
  );

  // pack the output beat
  assign m_axis_tdata = {1'b0, pt[2], pt[1], pt[0], dep, nrm[2], nrm[1], nrm[0], ovl, ovl};

endmodule

`default_nettype wire

>>> tb/sphere_box_contact_core_tb.sv
// sphere_box_contact_core_tb: self-checking bench for the sphere versus box contact core
// drives random and directed sphere/box pairs, predicts each contact and checks every beat
// depends on sbc_pkg and sphere_box_contact_core
`timescale 1ns / 100ps

module sphere_box_contact_core_tb;
  import sbc_pkg::*;

  localparam int          FracBits = FracBitsDef;
  localparam int          One      = 1 << FracBits;
  localparam logic [63:0] DepthMax = 64'h7FFF_FFFF;
  localparam int          Settle   = FracBits + 60;

  // input beat, first field in the lowest bits
  typedef struct packed {
    logic                   pad;
    logic [2:0][CoordW-1:0] hi;
    logic [2:0][CoordW-1:0] lo;
    logic [RadW-1:0]        r;
    logic [2:0][CoordW-1:0] c;
  } pair_t;

  // output beat, first field in the lowest bits
  typedef struct packed {
    logic                   pad;
    logic [2:0][CoordW-1:0] pt;
    logic [DepthW-1:0]      depth;
    logic [2:0][NormW-1:0]  n;
    logic                   pvalid;
    logic                   overlap;
  } contact_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  int idle_pct  = 0;
  int stall_pct = 0;

  sphere_box_contact_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // integer square root, rounded down
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected contact for one sphere/box pair
  function automatic contact_t predict_contact(pair_t p);
    contact_t    o;
    longint      c[3], lo[3], hi[3], gap[3], n[3], fd[6];
    longint      q, bestd, pt;
    logic [63:0] r, a, sq, len, m, depth;
    int          best;
    bit          outside;
    o       = '0;
    r       = 64'(p.r);
    outside = 1'b0;
    // clamp the center to the box
    for (int i = 0; i < 3; i++) begin
      c[i]  = longint'($signed(p.c[i]));
      lo[i] = longint'($signed(p.lo[i]));
      hi[i] = longint'($signed(p.hi[i]));
      if (c[i] < lo[i]) q = lo[i];
      else if (c[i] > hi[i]) q = hi[i];
      else q = c[i];
      gap[i] = c[i] - q;
      if (gap[i] != 0) outside = 1'b1;
    end
    if (outside) begin
      // exact overlap test against the squared radius
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        a = gap[i] < 0 ? -gap[i] : gap[i];
        if (a > r) return o;
        sq = sq + a * a;
      end
      if (sq > r * r) return o;
      len = root64(sq);
      for (int i = 0; i < 3; i++) begin
        a    = gap[i] < 0 ? -gap[i] : gap[i];
        m    = ((a << FracBits) + (len >> 1)) / len;
        n[i] = gap[i] < 0 ? -longint'(m) : longint'(m);
      end
      depth = r - len;
    end else begin
      // nearest face, earlier faces win ties
      fd[0] = c[0] - lo[0];
      fd[1] = hi[0] - c[0];
      fd[2] = c[1] - lo[1];
      fd[3] = hi[1] - c[1];
      fd[4] = c[2] - lo[2];
      fd[5] = hi[2] - c[2];
      best  = 0;
      bestd = fd[0];
      for (int i = 1; i < 6; i++) begin
        if (fd[i] < bestd) begin
          bestd = fd[i];
          best  = i;
        end
      end
      n[0] = 0;
      n[1] = 0;
      n[2] = 0;
      n[best / 2] = (best % 2) ? longint'(One) : -longint'(One);
      depth = r + (bestd > 0 ? 64'(bestd) : 64'd0);
      if (depth > DepthMax) depth = DepthMax;
    end
    o.overlap = 1'b1;
    o.pvalid  = 1'b1;
    o.depth   = depth[DepthW-1:0];
    // contact point with rounded offset and saturation
    for (int i = 0; i < 3; i++) begin
      o.n[i] = n[i][NormW-1:0];
      a      = n[i] < 0 ? -n[i] : n[i];
      m      = (a * r + (64'd1 << (FracBits - 1))) >> FracBits;
      pt     = n[i] < 0 ? c[i] + longint'(m) : c[i] - longint'(m);
      if (pt > 64'sh7FFF_FFFF) pt = 64'sh7FFF_FFFF;
      if (pt < -64'sh8000_0000) pt = -64'sh8000_0000;
      o.pt[i] = pt[31:0];
    end
    return o;
  endfunction

  // expected contacts in flight, checked in order
  class contact_scoreboard;
    contact_t contact_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function void note_pair(pair_t p);
      contact_q.push_back(predict_contact(p));
    endfunction

    function int pending();
      return contact_q.size();
    endfunction

    function void field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t %s expected %h got %h", $time, name, e, a);
      end
    endfunction

    function void check_contact(contact_t got);
      contact_t e;
      if (contact_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat expected none got %h", $time, got);
        return;
      end
      e = contact_q.pop_front();
      field("overlap", 64'(e.overlap), 64'(got.overlap));
      field("point_valid", 64'(e.pvalid), 64'(got.pvalid));
      field("normal_x", 64'(e.n[0]), 64'(got.n[0]));
      field("normal_y", 64'(e.n[1]), 64'(got.n[1]));
      field("normal_z", 64'(e.n[2]), 64'(got.n[2]));
      field("depth", 64'(e.depth), 64'(got.depth));
      field("point_x", 64'(e.pt[0]), 64'(got.pt[0]));
      field("point_y", 64'(e.pt[1]), 64'(got.pt[1]));
      field("point_z", 64'(e.pt[2]), 64'(got.pt[2]));
    endfunction
  endclass

  contact_scoreboard sb = new();

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_contact(contact_t'(m_axis_tdata));
  end

  function automatic int span(int unsigned w);
    return int'($urandom_range(2 * w)) - int'(w);
  endfunction

  function automatic pair_t mk(int cx, int cy, int cz, int unsigned r,
                               int l0, int l1, int l2, int h0, int h1, int h2);
    pair_t p;
    p       = '0;
    p.c[0]  = cx;
    p.c[1]  = cy;
    p.c[2]  = cz;
    p.r     = r[RadW-1:0];
    p.lo[0] = l0;
    p.lo[1] = l1;
    p.lo[2] = l2;
    p.hi[0] = h0;
    p.hi[1] = h1;
    p.hi[2] = h2;
    return p;
  endfunction

  // random pair, mostly spheres close to a sane box
  function automatic pair_t random_pair();
    pair_t       p;
    int          k, base, half, t;
    int unsigned r;
    p = '0;
    k = $urandom_range(99);
    if (k < 78) begin
      r = ($urandom_range(9) == 0) ? ($urandom & 32'h7FFF_FFFF) : $urandom_range(1 << 21);
      if (k >= 68) r = $urandom_range(3) * One;
      for (int i = 0; i < 3; i++) begin
        if (k >= 68) begin
          // coarse grid, frequent face ties
          p.lo[i] = span(3) * One;
          p.hi[i] = $signed(p.lo[i]) + $urandom_range(4) * One;
          p.c[i]  = span(5) * One;
        end else begin
          base    = span(1 << 28);
          half    = $urandom_range(1 << 20);
          p.lo[i] = base - half;
          p.hi[i] = base + half;
          if (k < 50) p.c[i] = base + span(half + (1 << 21) + (1 << 19));
          else p.c[i] = base + span(half);
        end
      end
      p.r = r[RadW-1:0];
    end else if (k < 90) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
      p.pad = 1'b0;
    end else begin
      // inverted box on one axis
      for (int i = 0; i < 3; i++) begin
        base    = span(1 << 24);
        half    = $urandom_range(1 << 18);
        p.lo[i] = base - half;
        p.hi[i] = base + half;
        p.c[i]  = base + span(half + (1 << 18));
      end
      t = $urandom_range(2);
      {p.lo[t], p.hi[t]} = {p.hi[t], p.lo[t]};
      p.r = $urandom_range(1 << 21);
    end
    return p;
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_pair(pair_t p);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pair(p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    pair_t list[$];
    int    idle_tab[5];
    int    stall_tab[5];
    int    mx, mn;
    idle_tab  = '{0, 80, 0, 23, 0};
    stall_tab = '{0, 0, 80, 23, 0};
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // separated, touching, diagonal and negative gaps
    list.push_back(mk(3 * One, 0, 0, One, -One, -One, -One, One, One, One));
    list.push_back(mk(2 * One, 0, 0, One, -One, -One, -One, One, One, One));
    list.push_back(mk(One + 100, One + 100, One + 100, One, -One, -One, -One, One, One, One));
    list.push_back(mk(-One - 30000, -One - 20000, 0, One, -One, -One, -One, One, One, One));
    // center inside, nearest face on each side
    list.push_back(mk(-3 * One, 0, 0, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(3 * One, 0, 0, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(0, -3 * One, 0, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(0, 3 * One, 0, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(0, 0, -3 * One, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(0, 0, 3 * One, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    // all faces tied, center on a face, zero radius
    list.push_back(mk(0, 0, 0, One, -One, -One, -One, One, One, One));
    list.push_back(mk(4 * One, 0, 0, One, -4 * One, -4 * One, -4 * One, 4 * One, 4 * One, 4 * One));
    list.push_back(mk(2 * One, 0, 0, 0, -One, -One, -One, One, One, One));
    list.push_back(mk(One / 2, 0, 0, 0, -One, -One, -One, One, One, One));
    // inverted box
    list.push_back(mk(0, 0, 0, 2 * One, One, -One, -One, -One, One, One));
    // full-range extremes and depth saturation
    list.push_back(mk(mx, mx, mx, mx, mn, mn, mn, mx, mx, mx));
    list.push_back(mk(mn, mn, mn, mx, mn, mn, mn, mx, mx, mx));
    list.push_back(mk(0, 0, 0, mx, mn, mn, mn, mx, mx, mx));
    // contact point saturating high and low
    list.push_back(mk(mx - 99, 0, 0, 1 << 30, mx, -One, -One, mx, One, One));
    list.push_back(mk(mn + 100, 0, 0, 1 << 30, mn, -One, -One, mn, One, One));
    // gap wider than any radius
    list.push_back(mk(mn, 0, 0, mx, mx, -One, -One, mx, One, One));
    list.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(mk(-1, -1, -1, mx, -1, -1, -1, -1, -1, -1));
    foreach (list[i]) send_pair(list[i]);

    // random phases with different idle and stall mixes
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int i = 0; i < 270; i++) send_pair(random_pair());
      if (ph == 1) drain();
    end
    drain();
    stall_pct = 0;
    repeat (Settle) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
